// ===== rtl/core/csa_pkg.sv =====
// ----------------------------------------------------------------------------
// Chunked slot allocator package
// Shared types, register indexes, status codes and a helper function.
// ----------------------------------------------------------------------------
package csa_pkg;

    localparam int MAX_CHUNKS_DEF = 256;
    localparam int MAX_SLOTS_DEF  = 1024;

    localparam int OFF_W  = 24;
    localparam int USED_W = 11;
    localparam int LIVE_W = 19;

    localparam logic [10:0] ITEMS_RST = 11'd1024;
    localparam logic [8:0]  LIMIT_RST = 9'd256;
    localparam logic [15:0] SIZE_RST  = 16'd16;
    localparam logic [4:0]  SHIFT_RST = 5'd14;
    localparam logic [4:0]  SHIFT_MIN = 5'd14;
    localparam logic [4:0]  SHIFT_MAX = 5'd16;

    localparam logic [15:0] LOW_MASK  = 16'hFFFF;
    localparam logic [31:0] WORD_FULL = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        IDX_ITEMS = 2'd0,
        IDX_LIMIT = 2'd1,
        IDX_SIZE  = 2'd2,
        IDX_SHIFT = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOCHUNK = 2'd1,
        ST_DOUBLE  = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef struct packed {
        logic              mode;
        logic [OFF_W-1:0]  free_offset;
    } in_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        chunk_index;
        logic [9:0]        slot_index;
        logic [OFF_W-1:0]  item_offset;
        logic              commit_chunk;
        logic              decommit_chunk;
        logic [LIVE_W-1:0] live_items;
    } out_rsp_t;

    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

    // Index of the lowest set bit; 31 when the word is all zero.
    function automatic logic [4:0] lowest_bit(input logic [31:0] v);
        logic [4:0] r;
        r = 5'd31;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) r = 5'(i);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/csa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module csa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/csa_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Sixteen-bit unsigned quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module csa_div
    import csa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [16:0] rem_reg;
    logic [15:0] quo_reg;
    logic [15:0] dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] trial;

    assign trial = {rem_reg[15:0], quo_reg[15]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (trial >= {1'b0, dvs_reg}) begin
                    rem_reg <= trial - {1'b0, dvs_reg};
                    quo_reg <= {quo_reg[14:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[14:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd15) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/core/chunked_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Chunked slot allocator
// Slab-style fixed-size slot allocator with two-level free bitmaps per chunk.
// ----------------------------------------------------------------------------
// An alloc from an active chunk adds a read-modify-write pass for each link
// patch; an alloc that commits a chunk adds a fill of its MAX_SLOTS/32 bitmap
// words; a free first waits on the bit-serial divider for its slot number.
// Throughput: one request at a time; the next request is taken as soon as the
// sequencer is idle, while the previous result may still wait at the output.
// Reset (synchronous, active low) empties both lists and clears counters; the
// memories need no clearing pass, since every entry is written before it is read.
module chunked_slot_allocator_top
    import csa_pkg::*;
#(
    parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
    parameter int MAX_SLOTS  = MAX_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_req_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_rsp_t    m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Link values carry one code beyond the last chunk, meaning "no chunk".
    localparam int LW     = $clog2(MAX_CHUNKS + 1);
    localparam int WORDS  = MAX_SLOTS / 32;
    localparam int WW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SW     = $clog2(MAX_SLOTS);
    localparam int SDEPTH = MAX_CHUNKS * WORDS;
    localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int MAW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int MW     = 32 + USED_W + 2 * LW;
    localparam logic [LW-1:0] NONE = LW'(MAX_CHUNKS);
    localparam logic [31:0] SUM_INIT =
        (WORDS >= 32) ? WORD_FULL : 32'((64'd1 << WORDS) - 64'd1);

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_DIV   = 17'h00002,
        S_FRD   = 17'h00004,
        S_FDAT  = 17'h00008,
        S_FUPD  = 17'h00010,
        S_MRD   = 17'h00020,
        S_MDAT  = 17'h00040,
        S_SWEEP = 17'h00080,
        S_FIND  = 17'h00100,
        S_WDAT  = 17'h00200,
        S_SLOT  = 17'h00400,
        S_AUPD  = 17'h00800,
        S_OFF   = 17'h01000,
        S_PRD   = 17'h02000,
        S_PWR   = 17'h04000,
        S_MWR   = 17'h08000,
        S_DONE  = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers and their saturated working values.
    logic [10:0] items_reg;
    logic [8:0]  limit_reg;
    logic [15:0] size_reg;
    logic [4:0]  shift_reg;
    logic [10:0] eff_items;
    logic [LW-1:0] eff_limit;
    logic [15:0] eff_size;
    logic [4:0]  eff_shift;

    assign eff_items = (items_reg < 11'd2) ? 11'd2 :
                       (32'(items_reg) > MAX_SLOTS) ? 11'(MAX_SLOTS) : items_reg;
    assign eff_limit = (32'(limit_reg) > MAX_CHUNKS) ? NONE : LW'(limit_reg);
    assign eff_size  = (size_reg == 16'd0) ? 16'd1 : size_reg;
    assign eff_shift = (shift_reg < SHIFT_MIN) ? SHIFT_MIN :
                       (shift_reg > SHIFT_MAX) ? SHIFT_MAX : shift_reg;

    // The configuration port never stalls; a write lands in the access phase.
    logic     cfg_wr;
    cfg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = cfg_idx_t'(paddr[3:2]);

    always_comb begin
        unique case (cfg_idx)
            IDX_ITEMS: prdata = 32'(items_reg);
            IDX_LIMIT: prdata = 32'(limit_reg);
            IDX_SIZE:  prdata = 32'(size_reg);
            IDX_SHIFT: prdata = 32'(shift_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            items_reg <= ITEMS_RST;
            limit_reg <= LIMIT_RST;
            size_reg  <= SIZE_RST;
            shift_reg <= SHIFT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                IDX_ITEMS: items_reg <= pwdata[10:0];
                IDX_LIMIT: limit_reg <= pwdata[8:0];
                IDX_SIZE:  size_reg  <= pwdata[15:0];
                IDX_SHIFT: shift_reg <= pwdata[4:0];
            endcase
        end
    end

    // Allocator state held in flip-flops: list heads and counters.
    logic [LW-1:0]     act_head_reg;
    logic [LW-1:0]     emp_head_reg;
    logic [LW-1:0]     fresh_reg;
    logic [LIVE_W-1:0] total_reg;

    // Working copy of the chunk under service, read from the metadata memory.
    logic [LW-1:0]     c_reg;
    logic [9:0]        fc_reg;
    logic [31:0]       sum_reg;
    logic [USED_W-1:0] used_reg;
    logic [LW-1:0]     prv_reg;
    logic [LW-1:0]     nxt_reg;
    logic [31:0]       word_reg;
    logic [WW-1:0]     w_reg;
    logic [SW-1:0]     s_reg;
    logic [SW+15:0]    prod_reg;
    logic [WW-1:0]     sweep_reg;

    // Result fields being built.
    status_t           status_reg;
    logic              commit_reg;
    logic              decommit_reg;
    logic [OFF_W-1:0]  ioff_reg;

    // Up to three link patches on neighbouring chunks, applied one by one as
    // read-modify-write passes over the metadata memory.
    logic [2:0]        pv_reg;
    logic [LW-1:0]     pt_reg  [3];
    logic              pp_reg  [3];
    logic [LW-1:0]     pval_reg[3];
    logic [1:0]        pick;

    assign pick = pv_reg[0] ? 2'd0 : (pv_reg[1] ? 2'd1 : 2'd2);

    // Output register.
    logic     m_valid_reg;
    out_rsp_t m_data_reg;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign s_ready = (state_reg == S_IDLE);

    // Divider for the slot number of a free request.
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     accept;

    assign accept           = s_valid && s_ready;
    assign div_req.start    = accept && s_data.mode;
    assign div_req.dividend = s_data.free_offset[15:0] & ~(LOW_MASK << eff_shift);
    assign div_req.divisor  = eff_size;

    csa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Metadata memory: summary word, use count, previous and next link.
    logic           meta_we;
    logic [MAW-1:0] meta_waddr;
    logic [MW-1:0]  meta_wdata;
    logic [MAW-1:0] meta_raddr;
    logic [MW-1:0]  meta_rdata;
    logic [31:0]       rd_sum;
    logic [USED_W-1:0] rd_used;
    logic [LW-1:0]     rd_prv;
    logic [LW-1:0]     rd_nxt;

    assign rd_sum  = meta_rdata[MW-1 -: 32];
    assign rd_used = meta_rdata[2*LW +: USED_W];
    assign rd_prv  = meta_rdata[LW +: LW];
    assign rd_nxt  = meta_rdata[0 +: LW];

    csa_ram #(.WIDTH(MW), .DEPTH(MAX_CHUNKS)) u_meta (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    // Slot bitmap memory: one bit per slot, set while the slot is free.
    logic           slot_we;
    logic [SAW-1:0] slot_waddr;
    logic [31:0]    slot_wdata;
    logic [SAW-1:0] slot_raddr;
    logic [31:0]    slot_rdata;

    csa_ram #(.WIDTH(32), .DEPTH(SDEPTH)) u_slot (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // Combinational helpers.
    logic [4:0]     sum_lb;
    logic [4:0]     word_lb;
    logic [10:0]    s_full;
    logic [WW-1:0]  fw;
    logic [31:0]    fbit;
    logic [31:0]    aword;
    logic [SAW-1:0] row_base;
    logic           on_act;
    logic [USED_W-1:0] used_inc;

    assign sum_lb   = lowest_bit(sum_reg);
    assign word_lb  = lowest_bit(word_reg);
    assign s_full   = 11'((32'(w_reg) << 5) | 32'(word_lb));
    assign fw       = WW'(s_reg >> 5);
    assign fbit     = 32'd1 << s_reg[4:0];
    assign aword    = word_reg & ~fbit;
    assign row_base = SAW'(32'(c_reg) * WORDS);
    assign on_act   = (prv_reg != NONE) || (act_head_reg == c_reg);
    assign used_inc = used_reg + USED_W'(1);

    always_comb begin
        meta_raddr = MAW'(c_reg);
        if (state_reg == S_PRD) begin
            meta_raddr = MAW'(pt_reg[pick]);
        end
        meta_we    = 1'b0;
        meta_waddr = MAW'(c_reg);
        meta_wdata = {sum_reg, used_reg, prv_reg, nxt_reg};
        if (state_reg == S_PWR) begin
            meta_we    = 1'b1;
            meta_waddr = MAW'(pt_reg[pick]);
            meta_wdata = meta_rdata;
            if (pp_reg[pick]) begin
                meta_wdata[LW +: LW] = pval_reg[pick];
            end else begin
                meta_wdata[0 +: LW] = pval_reg[pick];
            end
        end else if (state_reg == S_MWR) begin
            meta_we = 1'b1;
        end
    end

    always_comb begin
        slot_raddr = row_base + SAW'(fw);
        if (state_reg == S_FIND) begin
            slot_raddr = row_base + SAW'(sum_lb);
        end
        slot_we    = 1'b0;
        slot_waddr = row_base + SAW'(w_reg);
        slot_wdata = aword;
        unique case (state_reg)
            S_SWEEP: begin
                slot_we    = 1'b1;
                slot_waddr = row_base + SAW'(sweep_reg);
                slot_wdata = WORD_FULL;
            end
            S_AUPD: begin
                slot_we = 1'b1;
            end
            S_FUPD: begin
                slot_we    = !word_reg[s_reg[4:0]];
                slot_waddr = row_base + SAW'(fw);
                slot_wdata = word_reg | fbit;
            end
            default: begin
                slot_we = 1'b0;
            end
        endcase
    end

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_data.mode) begin
                        state_next = S_DIV;
                    end else if (act_head_reg != NONE || emp_head_reg != NONE) begin
                        state_next = S_MRD;
                    end else if (fresh_reg < eff_limit) begin
                        state_next = S_SWEEP;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (32'(fc_reg) >= 32'(fresh_reg) || 32'(fc_reg) >= MAX_CHUNKS ||
                        div_rsp.quotient >= 16'(eff_items)) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_FRD;
                    end
                end
            end
            S_FRD:   state_next = S_FDAT;
            S_FDAT:  state_next = S_FUPD;
            S_FUPD:  state_next = word_reg[s_reg[4:0]] ? S_DONE : S_PRD;
            S_MRD:   state_next = S_MDAT;
            S_MDAT:  state_next = commit_reg ? S_SWEEP : S_FIND;
            S_SWEEP: state_next = (sweep_reg == WW'(WORDS - 1)) ? S_FIND : S_SWEEP;
            S_FIND: begin
                if (sum_reg == 32'd0 || 32'(sum_lb) >= WORDS) begin
                    state_next = S_PRD;
                end else begin
                    state_next = S_WDAT;
                end
            end
            S_WDAT:  state_next = S_SLOT;
            S_SLOT:  state_next = (s_full >= eff_items) ? S_PRD : S_AUPD;
            S_AUPD:  state_next = S_OFF;
            S_OFF:   state_next = S_PRD;
            S_PRD:   state_next = (pv_reg == 3'd0) ? S_MWR : S_PWR;
            S_PWR:   state_next = S_PRD;
            S_MWR:   state_next = S_DONE;
            S_DONE:  state_next = (!m_valid_reg || m_ready) ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer: datapath and state updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            act_head_reg <= NONE;
            emp_head_reg <= NONE;
            fresh_reg    <= '0;
            total_reg    <= '0;
            pv_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        status_reg   <= ST_OK;
                        commit_reg   <= 1'b0;
                        decommit_reg <= 1'b0;
                        ioff_reg     <= '0;
                        s_reg        <= '0;
                        c_reg        <= '0;
                        pv_reg       <= '0;
                        sweep_reg    <= '0;
                        fc_reg       <= 10'(s_data.free_offset >> eff_shift);
                        if (!s_data.mode) begin
                            if (act_head_reg != NONE) begin
                                c_reg <= act_head_reg;
                            end else if (emp_head_reg != NONE) begin
                                c_reg      <= emp_head_reg;
                                commit_reg <= 1'b1;
                            end else if (fresh_reg < eff_limit) begin
                                // A never-used chunk goes straight onto the empty
                                // active list.
                                c_reg        <= fresh_reg;
                                fresh_reg    <= fresh_reg + LW'(1);
                                commit_reg   <= 1'b1;
                                act_head_reg <= fresh_reg;
                                sum_reg      <= SUM_INIT;
                                used_reg     <= '0;
                                prv_reg      <= NONE;
                                nxt_reg      <= NONE;
                            end else begin
                                status_reg <= ST_NOCHUNK;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        if (32'(fc_reg) >= 32'(fresh_reg) || 32'(fc_reg) >= MAX_CHUNKS ||
                            div_rsp.quotient >= 16'(eff_items)) begin
                            status_reg <= ST_RANGE;
                        end else begin
                            c_reg <= LW'(fc_reg);
                            s_reg <= SW'(div_rsp.quotient);
                        end
                    end
                end
                S_FDAT: begin
                    sum_reg  <= rd_sum;
                    used_reg <= rd_used;
                    prv_reg  <= rd_prv;
                    nxt_reg  <= rd_nxt;
                    word_reg <= slot_rdata;
                end
                S_FUPD: begin
                    if (word_reg[s_reg[4:0]]) begin
                        status_reg <= ST_DOUBLE;
                    end else begin
                        sum_reg   <= sum_reg | (32'd1 << fw);
                        used_reg  <= used_reg - USED_W'(1);
                        total_reg <= total_reg - LIVE_W'(1);
                        if (used_reg == USED_W'(1)) begin
                            // The chunk empties: off the active list, onto the
                            // empty list.
                            if (on_act) begin
                                if (prv_reg != NONE) begin
                                    pv_reg[0]   <= 1'b1;
                                    pt_reg[0]   <= prv_reg;
                                    pp_reg[0]   <= 1'b0;
                                    pval_reg[0] <= nxt_reg;
                                end else if (act_head_reg == c_reg) begin
                                    act_head_reg <= nxt_reg;
                                end
                                if (nxt_reg != NONE) begin
                                    pv_reg[1]   <= 1'b1;
                                    pt_reg[1]   <= nxt_reg;
                                    pp_reg[1]   <= 1'b1;
                                    pval_reg[1] <= prv_reg;
                                end
                            end
                            prv_reg <= NONE;
                            nxt_reg <= emp_head_reg;
                            if (emp_head_reg != NONE) begin
                                pv_reg[2]   <= 1'b1;
                                pt_reg[2]   <= emp_head_reg;
                                pp_reg[2]   <= 1'b1;
                                pval_reg[2] <= c_reg;
                            end
                            emp_head_reg <= c_reg;
                            decommit_reg <= 1'b1;
                        end else if (!on_act) begin
                            // A full chunk rejoins the active list at its head.
                            prv_reg <= NONE;
                            nxt_reg <= act_head_reg;
                            if (act_head_reg != NONE) begin
                                pv_reg[2]   <= 1'b1;
                                pt_reg[2]   <= act_head_reg;
                                pp_reg[2]   <= 1'b1;
                                pval_reg[2] <= c_reg;
                            end
                            act_head_reg <= c_reg;
                        end
                    end
                end
                S_MDAT: begin
                    if (commit_reg) begin
                        // Reuse of an emptied chunk: pop it from the empty list
                        // and push it onto the empty active list.
                        emp_head_reg <= rd_nxt;
                        if (rd_nxt != NONE) begin
                            pv_reg[0]   <= 1'b1;
                            pt_reg[0]   <= rd_nxt;
                            pp_reg[0]   <= 1'b1;
                            pval_reg[0] <= NONE;
                        end
                        act_head_reg <= c_reg;
                        sum_reg      <= SUM_INIT;
                        used_reg     <= '0;
                        prv_reg      <= NONE;
                        nxt_reg      <= NONE;
                    end else begin
                        sum_reg  <= rd_sum;
                        used_reg <= rd_used;
                        prv_reg  <= rd_prv;
                        nxt_reg  <= rd_nxt;
                    end
                end
                S_SWEEP: begin
                    sweep_reg <= sweep_reg + WW'(1);
                end
                S_FIND: begin
                    if (sum_reg == 32'd0 || 32'(sum_lb) >= WORDS) begin
                        status_reg <= ST_NOCHUNK;
                        commit_reg <= 1'b0;
                    end else begin
                        w_reg <= WW'(sum_lb);
                    end
                end
                S_WDAT: begin
                    word_reg <= slot_rdata;
                end
                S_SLOT: begin
                    if (s_full >= eff_items) begin
                        status_reg <= ST_NOCHUNK;
                        commit_reg <= 1'b0;
                    end else begin
                        s_reg <= SW'(s_full);
                    end
                end
                S_AUPD: begin
                    if (aword == 32'd0) begin
                        sum_reg <= sum_reg & ~(32'd1 << w_reg);
                    end
                    used_reg  <= used_inc;
                    total_reg <= total_reg + LIVE_W'(1);
                    prod_reg  <= (SW + 16)'(s_reg * eff_size);
                    if (32'(used_inc) >= 32'(eff_items)) begin
                        // The chunk fills; it is always the active head here.
                        act_head_reg <= nxt_reg;
                        if (nxt_reg != NONE) begin
                            pv_reg[1]   <= 1'b1;
                            pt_reg[1]   <= nxt_reg;
                            pp_reg[1]   <= 1'b1;
                            pval_reg[1] <= NONE;
                        end
                        prv_reg <= NONE;
                        nxt_reg <= NONE;
                    end
                end
                S_OFF: begin
                    ioff_reg <= OFF_W'(32'(c_reg) << eff_shift) + OFF_W'(prod_reg);
                end
                S_PWR: begin
                    pv_reg[pick] <= 1'b0;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.status          <= status_reg;
                        m_data_reg.chunk_index     <= (status_reg == ST_RANGE ||
                                                       status_reg == ST_NOCHUNK) ?
                                                      8'd0 : 8'(c_reg);
                        m_data_reg.slot_index      <= (status_reg == ST_RANGE ||
                                                       status_reg == ST_NOCHUNK) ?
                                                      10'd0 : 10'(s_reg);
                        m_data_reg.item_offset     <= ioff_reg;
                        m_data_reg.commit_chunk    <= commit_reg;
                        m_data_reg.decommit_chunk  <= decommit_reg;
                        m_data_reg.live_items      <= total_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // The live count moves only in the two update steps of the sequencer.
    a_total_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg == S_AUPD || state_reg == S_FUPD) |=> $stable(total_reg))
        else $error("live count changed outside an update step");

    // A patch pass is only entered while a patch is pending.
    a_patch_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PWR) |-> (pv_reg != 3'd0))
        else $error("patch write without a pending patch");

    // The active and empty lists never share a head chunk.
    a_heads_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        (act_head_reg != NONE) |-> (act_head_reg != emp_head_reg))
        else $error("active and empty lists share a chunk");

    // An out-of-range free reports no chunk and no slot.
    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status == ST_RANGE) |->
        (m_data_reg.chunk_index == 8'd0 && m_data_reg.slot_index == 10'd0))
        else $error("out-of-range result carries indices");

endmodule
